FILE: sv/ptr_pkg.sv
// Shared types and constants for the packet timestamp rebaser.
`default_nettype none

package ptr_pkg;

    localparam int unsigned UsecPerSec = 1000000;
    localparam int unsigned JumpSec    = 60;
    localparam int unsigned DivSteps   = 96;
    localparam int unsigned CntW       = $clog2(DivSteps);

    localparam logic [47:0] SecMax  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SecMin  = 48'h8000_0000_0000;
    localparam logic [48:0] QClip   = 49'h1_0000_0000_0000;
    localparam logic [47:0] DurMax  = 48'hFFFF_FFFF_FFFF;
    localparam logic [19:0] UsecMax = 20'd999999;

    localparam logic [2:0] CFG_LIVE_MODE  = 3'd0;
    localparam logic [2:0] CFG_TB_NUM     = 3'd1;
    localparam logic [2:0] CFG_TB_DEN     = 3'd2;
    localparam logic [2:0] CFG_FPS_NUM    = 3'd3;
    localparam logic [2:0] CFG_FPS_DEN    = 3'd4;
    localparam logic [2:0] CFG_IS_VIDEO   = 3'd5;
    localparam logic [2:0] CFG_SUB_STREAM = 3'd6;

    typedef struct packed {
        logic        live;
        logic [30:0] num;      // zero already replaced by one
        logic [30:0] den;
        logic [30:0] fps_num;
        logic [30:0] fps_den;
        logic        fps_ok;
        logic [7:0]  sub_stream;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESYNC,
        OP_CORRUPT,
        OP_ANCHOR,
        OP_ACCUM,
        OP_SET_DELTA,
        OP_SET_DUR,
        OP_SET_ZERO,
        OP_SET_FPSQ,
        OP_RPL_PREP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_F1,
        OP_MUL_F2,
        OP_MUL_US,
        OP_DIV_DEN,
        OP_DIV_FPS,
        OP_SAVE_Q,
        OP_LIVE_UPD,
        OP_RPL_OUT,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        logic resync;
        logic corrupt;
        logic live;
        logic known;
        logic pv;
        logic backward;
        logic big;
        logic dur_nz;
        logic fps_ok;
        logic div_done;
    } dp_st_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MLO,
        S_MHI,
        S_DGO,
        S_DWAIT,
        S_POST,
        S_JMP,
        S_F2,
        S_SAVEQ,
        S_MUS,
        S_LUPD,
        S_RUPD,
        S_FIN,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_CHECK,
        PH_DELTA,
        PH_FPS,
        PH_RPL,
        PH_USL,
        PH_USR
    } phase_t;

endpackage

`default_nettype wire

FILE: sv/ptr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module ptr_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [95:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [95:0]      quot,
    output logic [63:0]      rem
);
    import ptr_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [95:0]     quo_reg, quo_next;
    logic [63:0]     rem_reg, rem_next;
    logic [63:0]     dsr_reg, dsr_next;
    logic [64:0]     trial;
    logic            fits;

    assign trial = {rem_reg, quo_reg[95]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 64 bits hold it
            rem_next = fits ? 64'(trial - {1'b0, dsr_reg}) : trial[63:0];
            quo_next = {quo_reg[94:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DivSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: sv/ptr_cfg.sv
// Configuration register file.
`default_nettype none

module ptr_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output ptr_pkg::cfg_t    cfg
);
    import ptr_pkg::*;

    logic        live_reg;
    logic [30:0] tb_num_reg;
    logic [30:0] tb_den_reg;
    logic [30:0] fps_num_reg;
    logic [30:0] fps_den_reg;
    logic        is_video_reg;
    logic [7:0]  sub_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= 1'b1;
            tb_num_reg   <= 31'd1;
            tb_den_reg   <= 31'd90000;
            fps_num_reg  <= '0;
            fps_den_reg  <= '0;
            is_video_reg <= 1'b0;
            sub_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LIVE_MODE:  live_reg     <= cfg_data[0];
                CFG_TB_NUM:     tb_num_reg   <= cfg_data[30:0];
                CFG_TB_DEN:     tb_den_reg   <= cfg_data[30:0];
                CFG_FPS_NUM:    fps_num_reg  <= cfg_data[30:0];
                CFG_FPS_DEN:    fps_den_reg  <= cfg_data[30:0];
                CFG_IS_VIDEO:   is_video_reg <= cfg_data[0];
                CFG_SUB_STREAM: sub_reg      <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.live       = live_reg;
        cfg.num        = (tb_num_reg == '0) ? 31'd1 : tb_num_reg;
        cfg.den        = (tb_den_reg == '0) ? 31'd1 : tb_den_reg;
        cfg.fps_num    = fps_num_reg;
        cfg.fps_den    = fps_den_reg;
        cfg.fps_ok     = is_video_reg && (fps_num_reg != '0) && (fps_den_reg != '0);
        cfg.sub_stream = sub_reg;
    end

endmodule

`default_nettype wire

FILE: sv/ptr_dp.sv
// Datapath: packet and stream state, shared multiplier, divider, result registers.
`default_nettype none

module ptr_dp (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ptr_pkg::cfg_t   cfg,
    input  wire ptr_pkg::dp_op_t op,
    output ptr_pkg::dp_st_t   st,
    input  wire logic         kind,
    input  wire logic         pts_valid,
    input  wire logic [47:0]  pts,
    input  wire logic [31:0]  duration,
    input  wire logic         key_flag,
    input  wire logic         corrupt_flag,
    input  wire logic [31:0]  wall_sec,
    input  wire logic [19:0]  wall_usec,
    output logic              status,
    output logic              key_frame,
    output logic [7:0]        stream_id,
    output logic [47:0]       ts_sec,
    output logic [20:0]       ts_usec
);
    import ptr_pkg::*;

    // captured packet
    logic        kind_reg, pv_reg, key_reg, corrupt_reg;
    logic [47:0] pts_reg;
    logic [31:0] dur_reg;
    logic [31:0] wsec_reg;
    logic [19:0] wusec_reg;

    // stream state
    logic [47:0] last_pts_reg;
    logic        known_reg;
    logic [47:0] last_dur_reg;
    logic [47:0] base_sec_reg;
    logic [19:0] base_usec_reg;
    logic        gop_reg;

    // working registers
    logic [63:0] a_reg;
    logic [63:0] prod_lo_reg, prod_hi_reg;
    logic [63:0] fdiv_reg;
    logic [48:0] q_reg;
    logic [30:0] rem_reg;
    logic        neg_reg;

    // result
    logic        status_reg, key_out_reg;
    logic [7:0]  sid_reg;
    logic [47:0] sec_reg;
    logic [20:0] usec_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] product;
    logic [95:0] dividend;
    logic [63:0] divisor;
    logic        div_start, div_done;
    logic [95:0] quot;
    logic [63:0] drem;

    logic [19:0] wusec_sat;
    logic [48:0] diff;
    logic        backward;
    logic [47:0] rpl_p;
    logic [48:0] rpl_mag;
    logic [48:0] q_sat;
    logic [20:0] u_sum, u_fin;
    logic        u_wrap;
    logic [49:0] s_sum, s_fin;
    logic [47:0] s_sat;
    logic [48:0] acc;
    logic [47:0] rpl_sec;
    logic [20:0] rpl_usec;
    logic        gop_new;

    assign wusec_sat = (wall_usec > UsecMax) ? UsecMax : wall_usec;
    assign diff      = {pts_reg[47], pts_reg} - {last_pts_reg[47], last_pts_reg};
    assign backward  = $signed(pts_reg) < $signed(last_pts_reg);

    assign rpl_p   = pv_reg ? pts_reg : (known_reg ? last_pts_reg : 48'd0);
    assign rpl_mag = rpl_p[47] ? 49'(49'd0 - {1'b1, rpl_p}) : {1'b0, rpl_p};

    always_comb
    begin
        unique case (op)
            OP_MUL_LO:
            begin
                mul_a = a_reg[31:0];
                mul_b = {1'b0, cfg.num};
            end
            OP_MUL_HI:
            begin
                mul_a = a_reg[63:32];
                mul_b = {1'b0, cfg.num};
            end
            OP_MUL_F1:
            begin
                mul_a = {1'b0, cfg.fps_den};
                mul_b = {1'b0, cfg.den};
            end
            OP_MUL_F2:
            begin
                mul_a = {1'b0, cfg.fps_num};
                mul_b = {1'b0, cfg.num};
            end
            OP_MUL_US:
            begin
                mul_a = {1'b0, rem_reg};
                mul_b = 32'(UsecPerSec);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product   = mul_a * mul_b;
    assign dividend  = {prod_hi_reg, 32'd0} + {32'd0, prod_lo_reg};
    assign divisor   = (op == OP_DIV_FPS) ? fdiv_reg : {33'd0, cfg.den};
    assign div_start = (op == OP_DIV_DEN) || (op == OP_DIV_FPS);

    ptr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quot     (quot),
        .rem      (drem)
    );

    assign q_sat = (quot > {47'd0, QClip}) ? QClip : quot[48:0];

    // live accumulation of the converted delta onto the base
    assign u_sum  = {1'b0, quot[19:0]} + {1'b0, base_usec_reg};
    assign u_wrap = u_sum >= 21'(UsecPerSec);
    assign u_fin  = u_wrap ? 21'(u_sum - 21'(UsecPerSec)) : u_sum;
    assign s_sum  = {1'b0, q_reg} + {2'd0, base_sec_reg};
    assign s_fin  = s_sum + {49'd0, u_wrap};
    assign s_sat  = (s_fin > {2'd0, SecMax}) ? SecMax : s_fin[47:0];

    assign acc = {1'b0, last_dur_reg} + {17'd0, dur_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            rpl_sec  = (q_reg > {1'b0, SecMax}) ? SecMin : 48'(49'd0 - q_reg);
            rpl_usec = 21'(21'd0 - {1'b0, quot[19:0]});
        end
        else
        begin
            rpl_sec  = (q_reg > {1'b0, SecMax}) ? SecMax : q_reg[47:0];
            rpl_usec = {1'b0, quot[19:0]};
        end
    end

    assign gop_new = gop_reg | key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pts_reg  <= '0;
            known_reg     <= 1'b0;
            last_dur_reg  <= '0;
            base_sec_reg  <= '0;
            base_usec_reg <= '0;
            gop_reg       <= 1'b0;
        end
        else
        begin
            unique case (op)
                OP_RESYNC:
                    gop_reg <= 1'b0;
                OP_ANCHOR:
                begin
                    if (pv_reg)
                    begin
                        last_pts_reg <= pts_reg;
                        known_reg    <= 1'b1;
                    end
                    last_dur_reg  <= {16'd0, dur_reg};
                    base_sec_reg  <= {16'd0, wsec_reg};
                    base_usec_reg <= wusec_reg;
                end
                OP_ACCUM:
                    last_dur_reg <= acc[48] ? DurMax : acc[47:0];
                OP_RPL_PREP:
                begin
                    if (pv_reg)
                    begin
                        last_pts_reg <= pts_reg;
                        known_reg    <= 1'b1;
                        last_dur_reg <= {16'd0, dur_reg};
                    end
                end
                OP_LIVE_UPD:
                begin
                    base_sec_reg  <= s_sat;
                    base_usec_reg <= u_fin[19:0];
                    last_pts_reg  <= pts_reg;
                    last_dur_reg  <= {16'd0, dur_reg};
                end
                OP_FIN:
                    gop_reg <= gop_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                kind_reg    <= kind;
                pv_reg      <= pts_valid;
                pts_reg     <= pts;
                dur_reg     <= duration;
                key_reg     <= key_flag;
                corrupt_reg <= corrupt_flag;
                wsec_reg    <= wall_sec;
                wusec_reg   <= wusec_sat;
            end
            OP_CORRUPT:
            begin
                status_reg  <= 1'b1;
                key_out_reg <= key_reg;
                sid_reg     <= cfg.sub_stream;
                sec_reg     <= '0;
                usec_reg    <= '0;
            end
            OP_SET_DELTA: a_reg <= {16'd0, diff[47:0]};
            OP_SET_DUR:   a_reg <= {16'd0, last_dur_reg};
            OP_SET_ZERO:  a_reg <= '0;
            OP_SET_FPSQ:  a_reg <= quot[63:0];
            OP_RPL_PREP:
            begin
                a_reg   <= {15'd0, rpl_mag};
                neg_reg <= rpl_p[47];
            end
            OP_MUL_LO: prod_lo_reg <= product;
            OP_MUL_HI: prod_hi_reg <= product;
            OP_MUL_F1, OP_MUL_US:
            begin
                prod_lo_reg <= product;
                prod_hi_reg <= '0;
            end
            OP_MUL_F2: fdiv_reg <= product;
            OP_SAVE_Q:
            begin
                q_reg   <= q_sat;
                rem_reg <= drem[30:0];
            end
            OP_RPL_OUT:
            begin
                sec_reg  <= rpl_sec;
                usec_reg <= rpl_usec;
            end
            OP_FIN:
            begin
                status_reg  <= ~gop_new;
                key_out_reg <= key_reg;
                sid_reg     <= cfg.sub_stream;
                if (cfg.live)
                begin
                    sec_reg  <= base_sec_reg;
                    usec_reg <= {1'b0, base_usec_reg};
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st.resync   = kind_reg;
        st.corrupt  = corrupt_reg;
        st.live     = cfg.live;
        st.known    = known_reg;
        st.pv       = pv_reg;
        st.backward = backward;
        st.big      = quot > 96'(JumpSec);
        st.dur_nz   = last_dur_reg != '0;
        st.fps_ok   = cfg.fps_ok;
        st.div_done = div_done;
    end

    assign status    = status_reg;
    assign key_frame = key_out_reg;
    assign stream_id = sid_reg;
    assign ts_sec    = sec_reg;
    assign ts_usec   = usec_reg;

endmodule

`default_nettype wire

FILE: sv/ptr_ctrl.sv
// Controller state machine sequencing the datapath.
`default_nettype none

module ptr_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire ptr_pkg::dp_st_t st,
    output ptr_pkg::dp_op_t  op
);
    import ptr_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_CHECK;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_EVAL;
            S_EVAL:
            begin
                priority if (st.resync)
                    state_next = S_IDLE;
                else if (st.corrupt)
                    state_next = S_OUT;
                else if (st.live && (!st.known || !st.pv))
                    state_next = S_FIN;
                else if (st.live && st.backward)
                    state_next = S_JMP;
                else if (st.live)
                begin
                    state_next = S_MLO;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    state_next = S_MLO;
                    phase_next = PH_RPL;
                end
            end
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_DGO;
            S_DGO:   state_next = S_DWAIT;
            S_DWAIT:
                if (st.div_done)
                    state_next = S_POST;
            S_POST:
            begin
                unique case (phase_reg)
                    PH_CHECK:
                        if (st.big)
                            state_next = S_JMP;
                        else
                        begin
                            state_next = S_SAVEQ;
                            phase_next = PH_USL;
                        end
                    PH_DELTA:
                    begin
                        state_next = S_SAVEQ;
                        phase_next = PH_USL;
                    end
                    PH_FPS:
                    begin
                        state_next = S_MLO;
                        phase_next = PH_DELTA;
                    end
                    PH_RPL:
                    begin
                        state_next = S_SAVEQ;
                        phase_next = PH_USR;
                    end
                    PH_USL:  state_next = S_LUPD;
                    PH_USR:  state_next = S_RUPD;
                    default: state_next = S_IDLE;
                endcase
            end
            S_JMP:
            begin
                if (!st.dur_nz && st.fps_ok)
                    state_next = S_F2;
                else
                begin
                    state_next = S_MLO;
                    phase_next = PH_DELTA;
                end
            end
            S_F2:
            begin
                state_next = S_DGO;
                phase_next = PH_FPS;
            end
            S_SAVEQ: state_next = S_MUS;
            S_MUS:   state_next = S_DGO;
            S_LUPD:  state_next = S_FIN;
            S_RUPD:  state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op        = OP_NONE;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    op = OP_LOAD;
            end
            S_EVAL:
            begin
                priority if (st.resync)
                    op = OP_RESYNC;
                else if (st.corrupt)
                    op = OP_CORRUPT;
                else if (st.live && !st.known)
                    op = OP_ANCHOR;
                else if (st.live && !st.pv)
                    op = OP_ACCUM;
                else if (st.live && st.backward)
                    op = OP_NONE;
                else if (st.live)
                    op = OP_SET_DELTA;
                else
                    op = OP_RPL_PREP;
            end
            S_MLO: op = OP_MUL_LO;
            S_MHI: op = OP_MUL_HI;
            S_DGO: op = (phase_reg == PH_FPS) ? OP_DIV_FPS : OP_DIV_DEN;
            S_POST:
                if (phase_reg == PH_FPS)
                    op = OP_SET_FPSQ;
            S_JMP:
            begin
                priority if (st.dur_nz)
                    op = OP_SET_DUR;
                else if (st.fps_ok)
                    op = OP_MUL_F1;
                else
                    op = OP_SET_ZERO;
            end
            S_F2:    op = OP_MUL_F2;
            S_SAVEQ: op = OP_SAVE_Q;
            S_MUS:   op = OP_MUL_US;
            S_LUPD:  op = OP_LIVE_UPD;
            S_RUPD:  op = OP_RPL_OUT;
            S_FIN:   op = OP_FIN;
            S_OUT:   out_valid = 1'b1;
            default: op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/packet_timestamp_rebaser.sv
// Top level of the packet timestamp rebaser.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_stall  | kind pts_valid pts duration key_flag
//          |           |                      | corrupt_flag wall_sec wall_usec
//  out     | output    | out_valid / out_stall| status key_frame stream_id ts_sec ts_usec
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One packet at a time. Packets that need division use the shared 96-step divider:
// replay and normal live packets take two passes, a live jump takes two to four.
// Resync, corrupt, anchor and no-pts live packets use no divider pass. Reset is
// asynchronous; no clearing pass. A stalled result holds the block; the next
// transaction is taken once the result has left.
`default_nettype none

module packet_timestamp_rebaser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic        pts_valid,
    input  wire logic [47:0] pts,
    input  wire logic [31:0] duration,
    input  wire logic        key_flag,
    input  wire logic        corrupt_flag,
    input  wire logic [31:0] wall_sec,
    input  wire logic [19:0] wall_usec,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic             key_frame,
    output logic [7:0]       stream_id,
    output logic [47:0]      ts_sec,
    output logic [20:0]      ts_usec,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import ptr_pkg::*;

    cfg_t   cfg;
    dp_op_t op;
    dp_st_t st;

    ptr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .op        (op)
    );

    ptr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .op           (op),
        .st           (st),
        .kind         (kind),
        .pts_valid    (pts_valid),
        .pts          (pts),
        .duration     (duration),
        .key_flag     (key_flag),
        .corrupt_flag (corrupt_flag),
        .wall_sec     (wall_sec),
        .wall_usec    (wall_usec),
        .status       (status),
        .key_frame    (key_frame),
        .stream_id    (stream_id),
        .ts_sec       (ts_sec),
        .ts_usec      (ts_usec)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the packet timestamp rebaser.
`timescale 1ns / 100ps

module testbench;
    import ptr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic        pts_valid = 1'b0;
    logic [47:0] pts = '0;
    logic [31:0] duration = '0;
    logic        key_flag = 1'b0;
    logic        corrupt_flag = 1'b0;
    logic [31:0] wall_sec = '0;
    logic [19:0] wall_usec = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        key_frame;
    logic [7:0]  stream_id;
    logic [47:0] ts_sec;
    logic [20:0] ts_usec;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic        status;
        logic        key_frame;
        logic [7:0]  stream_id;
        logic [47:0] ts_sec;
        logic [20:0] ts_usec;
    } stamp_t;

    // predictor copy of registers and state
    logic        m_live;
    logic [30:0] m_num, m_den, m_fps_num, m_fps_den;
    logic        m_video;
    logic [7:0]  m_stream;
    logic signed [47:0] m_last_pts;
    logic        m_known;
    logic [47:0] m_last_dur;
    logic [47:0] m_base_sec;
    logic [19:0] m_base_usec;
    logic        m_gop;

    stamp_t pending_stamps[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    packet_timestamp_rebaser u_top (.*);

    always #10 clk = ~clk;

    // q = min(a*m/d, 2^48), r = a*m mod d
    task automatic scale_ticks(input logic [63:0] a, input logic [63:0] m,
                               input logic [63:0] d, output logic [63:0] q,
                               output logic [63:0] r);
        logic [127:0] p;
        logic [127:0] qq;
        p  = a * m;
        qq = p / d;
        r  = 64'(p % d);
        q  = (qq > 128'h1_0000_0000_0000) ? 64'h1_0000_0000_0000 : 64'(qq);
    endtask

    task automatic predict_stamp(input logic k, input logic pv, input logic [47:0] p_raw,
                                 input logic [31:0] dur, input logic key, input logic bad,
                                 input logic [31:0] wsec, input logic [19:0] wusec_in);
        logic [63:0] num, den, q, r, delta, u, s, mag;
        logic signed [47:0] p;
        logic signed [63:0] pv64;
        logic [19:0] wusec;
        logic jump;
        stamp_t e;
        num = (m_num == 0) ? 64'd1 : 64'(m_num);
        den = (m_den == 0) ? 64'd1 : 64'(m_den);
        p = p_raw;
        if (k)
        begin
            m_gop = 1'b0;
            return;
        end
        e = '{1'b1, key, m_stream, 48'd0, 21'd0};
        if (bad)
        begin
            pending_stamps.push_back(e);
            return;
        end
        wusec = (wusec_in > UsecMax) ? UsecMax : wusec_in;
        if (m_live)
        begin
            if (!m_known)
            begin
                if (pv)
                begin
                    m_last_pts = p;
                    m_known = 1'b1;
                end
                m_last_dur = 48'(dur);
                m_base_sec = 48'(wsec);
                m_base_usec = wusec;
            end
            else if (!pv)
            begin
                s = 64'(m_last_dur) + 64'(dur);
                m_last_dur = (s > 64'(DurMax)) ? DurMax : s[47:0];
            end
            else
            begin
                delta = 0;
                jump = (p < m_last_pts);
                if (!jump)
                begin
                    delta = 64'(64'(signed'(p)) - 64'(signed'(m_last_pts)));
                    scale_ticks(delta, num, den, q, r);
                    jump = (q > JumpSec);
                end
                if (jump)
                begin
                    if (m_last_dur > 0)
                        delta = 64'(m_last_dur);
                    else if (m_video && m_fps_den != 0 && m_fps_num != 0)
                        delta = (64'(m_fps_den) * den) / (64'(m_fps_num) * num);
                    else
                        delta = 0;
                end
                scale_ticks(delta, num, den, q, r);
                u = r * UsecPerSec / den + 64'(m_base_usec);
                s = q + 64'(m_base_sec);
                if (u >= UsecPerSec)
                begin
                    u = u - UsecPerSec;
                    s = s + 1;
                end
                if (s > 64'(SecMax))
                    s = 64'(SecMax);
                m_base_sec = s[47:0];
                m_base_usec = u[19:0];
                m_last_pts = p;
                m_last_dur = 48'(dur);
            end
            e.ts_sec = m_base_sec;
            e.ts_usec = 21'(m_base_usec);
        end
        else
        begin
            if (pv)
            begin
                pv64 = p;
                m_last_pts = p;
                m_known = 1'b1;
                m_last_dur = 48'(dur);
            end
            else
                pv64 = m_known ? 64'(signed'(m_last_pts)) : 64'sd0;
            mag = (pv64 < 0) ? 64'(-pv64) : 64'(pv64);
            scale_ticks(mag, num, den, q, r);
            r = r * UsecPerSec / den;
            if (pv64 < 0)
            begin
                e.ts_sec = (q > 64'(SecMax)) ? SecMin : 48'(-q);
                e.ts_usec = 21'(-r);
            end
            else
            begin
                e.ts_sec = (q > 64'(SecMax)) ? SecMax : q[47:0];
                e.ts_usec = 21'(r);
            end
        end
        if (key)
            m_gop = 1'b1;
        e.status = ~m_gop;
        pending_stamps.push_back(e);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LIVE_MODE:  m_live = val[0];
            CFG_TB_NUM:     m_num = val[30:0];
            CFG_TB_DEN:     m_den = val[30:0];
            CFG_FPS_NUM:    m_fps_num = val[30:0];
            CFG_FPS_DEN:    m_fps_den = val[30:0];
            CFG_IS_VIDEO:   m_video = val[0];
            CFG_SUB_STREAM: m_stream = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_packet(input logic k, input logic pv, input logic [47:0] p,
                               input logic [31:0] dur, input logic key, input logic bad,
                               input logic [31:0] wsec, input logic [19:0] wusec);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        kind <= k;
        pts_valid <= pv;
        pts <= p;
        duration <= dur;
        key_flag <= key;
        corrupt_flag <= bad;
        wall_sec <= wsec;
        wall_usec <= wusec;
        do @(posedge clk); while (in_stall);
        predict_stamp(k, pv, p, dur, key, bad, wsec, wusec);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every result, then the worst-case item latency before touching config
    task automatic drain();
        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        stamp_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, key_frame, stream_id, ts_sec, ts_usec};
            if (pending_stamps.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_stamps.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result differs: expected %p actual %p", want, got);
                end
            end
        end
    end

    function automatic logic [47:0] rand_pts48();
        return {16'($urandom_range(65535)), $urandom()};
    endfunction

    task automatic test_directed_replay();
        write_reg(CFG_LIVE_MODE, 0);
        write_reg(CFG_SUB_STREAM, 8'hFF);
        write_reg(CFG_TB_NUM, 32'h7FFF_FFFF);
        write_reg(CFG_TB_DEN, 1);
        send_packet(0, 0, 0, 0, 0, 0, 0, 0);                 // no pts seen yet, pre-key
        send_packet(0, 1, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0);
        send_packet(0, 1, 48'h8000_0000_0000, 0, 0, 0, 0, 0);
        send_packet(0, 0, 0, 0, 0, 0, 0, 0);                 // hold last pts
        drain();
        write_reg(CFG_TB_NUM, 0);                            // zero read as one
        write_reg(CFG_TB_DEN, 0);
        send_packet(0, 1, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_TB_NUM, 1);
        write_reg(CFG_TB_DEN, 32'h7FFF_FFFF);
        send_packet(0, 1, 48'h8000_0000_0001, 0, 0, 0, 0, 0); // negative truncation
        send_packet(0, 1, 48'h0000_1234_5678, 0, 0, 1, 0, 0); // corrupt
        send_packet(1, 0, 0, 0, 0, 0, 0, 0);                   // resync
        send_packet(0, 1, 48'd5, 0, 0, 0, 0, 0);               // gate closed again
        send_packet(0, 1, 48'd6, 0, 1, 0, 0, 0);
        drain();
    endtask

    task automatic test_directed_live();
        write_reg(CFG_LIVE_MODE, 1);
        write_reg(CFG_TB_NUM, 1);
        write_reg(CFG_TB_DEN, 90000);
        write_reg(CFG_FPS_NUM, 25);
        write_reg(CFG_FPS_DEN, 1);
        write_reg(CFG_IS_VIDEO, 1);
        write_reg(CFG_SUB_STREAM, 0);
        send_packet(0, 0, 0, 100, 1, 0, 32'hFFFF_FFFF, 20'hFFFFF); // no pts, pts already known: accumulate duration
        send_packet(0, 1, 1000, 0, 0, 0, 32'hFFFF_FFFF, 20'hFFFFF); // forward step from the last pts
        send_packet(0, 1, 4600, 3600, 0, 0, 0, 0);
        send_packet(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);       // accumulate duration
        send_packet(0, 1, 100, 0, 0, 0, 0, 0);                 // backward: duration
        send_packet(0, 1, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0);  // forward jump: fps
        drain();
        write_reg(CFG_IS_VIDEO, 0);
        send_packet(0, 1, 48'h8000_0000_0000, 0, 0, 0, 0, 0);  // jump: zero
        send_packet(0, 1, 48'h8000_0000_0000 + 48'd5400000, 7, 0, 0, 0, 0); // 60 s, no jump
        send_packet(0, 1, 0, 0, 1, 1, 5, 5);                   // corrupt
        drain();
    endtask

    task automatic test_random(input int count);
        int i;
        logic [47:0] p;
        p = rand_pts48();
        for (i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                drain();
                write_reg(CFG_LIVE_MODE, $urandom_range(1));
                write_reg(CFG_TB_NUM, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3));
                write_reg(CFG_TB_DEN, ($urandom_range(3) == 0) ? $urandom()
                                      : $urandom_range(100000));
                write_reg(CFG_FPS_NUM, ($urandom_range(3) == 0) ? $urandom()
                                       : $urandom_range(60));
                write_reg(CFG_FPS_DEN, ($urandom_range(3) == 0) ? $urandom()
                                       : $urandom_range(2));
                write_reg(CFG_IS_VIDEO, $urandom_range(1));
                write_reg(CFG_SUB_STREAM, $urandom_range(255));
                case ((i / 150) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                    default: begin send_idle_pct = 17; recv_stall_pct = 17; end
                endcase
            end
            // mostly a monotonic stream with small steps, some big jumps and noise
            case ($urandom_range(9))
                0: p = rand_pts48();
                1: p = p - $urandom_range(10000);
                default: p = p + $urandom_range(20000);
            endcase
            send_packet($urandom_range(39) == 0, $urandom_range(7) != 0, p,
                        ($urandom_range(3) == 0) ? $urandom() : $urandom_range(5000),
                        $urandom_range(4) == 0, $urandom_range(19) == 0,
                        $urandom(), ($urandom_range(9) == 0) ? 20'($urandom())
                                                             : 20'($urandom_range(999999)));
        end
        drain();
    endtask

    initial
    begin
        m_live = 1'b1; m_num = 1; m_den = 90000; m_fps_num = 0; m_fps_den = 0;
        m_video = 1'b0; m_stream = 0; m_last_pts = 0; m_known = 1'b0;
        m_last_dur = 0; m_base_sec = 0; m_base_usec = 0; m_gop = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_replay();
        test_directed_live();
        test_random(1150);
        if (errors == 0)
            $display("packet_timestamp_rebaser: match");
        else
            $display("packet_timestamp_rebaser: mismatch");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("packet_timestamp_rebaser: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ptr_pkg.sv
sv/ptr_div.sv
sv/ptr_cfg.sv
sv/ptr_dp.sv
sv/ptr_ctrl.sv
sv/packet_timestamp_rebaser.sv
tb/sv/testbench.sv
